FILE: rtl/core/alfr_pkg.sv
// Shared types and constants for the ASCII length frame receiver.
// Used by alfr_ctrl, alfr_obuf and ascii_length_frame_receiver. No dependencies.
package alfr_pkg;

    // Frame marker characters
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_U    = 8'h55;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Width of the accumulated decimal length (four digits, up to 9999)
    localparam int LEN_W = 14;

    // Smallest legal total frame length
    localparam logic [LEN_W-1:0] MIN_FRAME = 14'd12;

    // Status codes reported with every byte
    localparam logic [2:0] ST_IN_FRAME = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_HDR_ERR  = 3'd2;
    localparam logic [2:0] ST_LEN_ERR  = 3'd3;
    localparam logic [2:0] ST_TRL_ERR  = 3'd4;

    // One result item
    typedef struct packed {
        logic [7:0]  byte_echo;
        logic [9:0]  byte_index;
        logic [2:0]  status;
        logic [10:0] frame_length;
    } t_result;

endpackage

FILE: rtl/core/alfr_ctrl.sv
// Frame parser: phase, byte counter and length accumulator, one byte per cycle while bytes are accepted.
// Depends on alfr_pkg for characters, status codes and the result type.
module alfr_ctrl
    import alfr_pkg::*;
#(
    parameter int MAX_FRAME = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic [7:0] i_byte,
    output t_result o_result
);

    localparam int CW = $clog2(MAX_FRAME);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_END    = 2'd3;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

    logic [1:0]       r_phase, n_phase;
    logic [CW-1:0]    r_count, n_count;
    logic [LEN_W-1:0] r_len, n_len;

    logic [LEN_W-1:0] idx_w;
    logic [LEN_W:0]   idx_p1;
    logic [LEN_W-1:0] len_m3, len_m2;
    logic [LEN_W-1:0] acc;
    logic [3:0]       digit;
    logic             is_digit;
    logic [CW+9:0]    idx_ext;
    logic [7:0]       want;
    logic [2:0]       status;
    logic [10:0]      flen;
    logic             drop;

    // Derive comparison operands
    always_comb begin
        idx_w    = LEN_W'(r_count);
        idx_p1   = {1'b0, idx_w} + 1'b1;
        len_m3   = r_len - LEN_W'(3);
        len_m2   = r_len - LEN_W'(2);
        digit    = 4'(i_byte - CH_ZERO);
        is_digit = i_byte inside {[CH_ZERO:CH_NINE]};
        // times ten as shift-and-add, then add the new digit
        acc      = LEN_W'({r_len[LEN_W-4:0], 3'b000} + {r_len[LEN_W-2:0], 1'b0}
                   + LEN_W'(digit));
        idx_ext  = {10'b0, r_count};
    end

    // Check the byte against the frame layout and advance the phase
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        status  = ST_IN_FRAME;
        flen    = '0;
        drop    = 1'b0;
        want    = CH_D;
        case (r_phase)
            PH_HEADER: begin
                if ((r_count == CW'(0) && i_byte != CH_E) ||
                    (r_count == CW'(1) && i_byte != CH_C) ||
                    (r_count == CW'(2) && i_byte != CH_U)) begin
                    status = ST_HDR_ERR;
                    drop   = 1'b1;
                end else if (r_count >= CW'(4)) begin
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (!is_digit) begin
                    status = ST_LEN_ERR;
                    drop   = 1'b1;
                end else begin
                    n_len = acc;
                    if (r_count >= CW'(8)) begin
                        if (acc < MIN_FRAME || acc > MAX_LEN) begin
                            status = ST_LEN_ERR;
                            drop   = 1'b1;
                        end else if (acc == MIN_FRAME) begin
                            n_phase = PH_END;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA: begin
                if (idx_p1 >= {1'b0, len_m3}) begin
                    n_phase = PH_END;
                end
            end
            default: begin
                if (idx_w == len_m3) begin
                    want = CH_E;
                end else if (idx_w == len_m2) begin
                    want = CH_N;
                end
                if (i_byte != want) begin
                    status = ST_TRL_ERR;
                    drop   = 1'b1;
                end else if (idx_p1 >= {1'b0, r_len}) begin
                    status = ST_COMPLETE;
                    flen   = r_len[10:0];
                    drop   = 1'b1;
                end
            end
        endcase

        // resync on error or completion
        if (drop) begin
            n_phase = PH_HEADER;
            n_count = '0;
            n_len   = '0;
        end else begin
            n_count = r_count + 1'b1;
        end
    end

    // Build the result item
    always_comb begin
        o_result.byte_echo    = i_byte;
        o_result.byte_index   = idx_ext[9:0];
        o_result.status       = status;
        o_result.frame_length = flen;
    end

    // Hold parser state, advance on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
            r_len   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_len   <= n_len;
        end
    end

`ifndef ASSERT_OFF
    a_header_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_count <= CW'(4))
        else $error("header phase past byte 4");
    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LENGTH |-> (r_count >= CW'(5) && r_count <= CW'(8)))
        else $error("length phase outside bytes 5 to 8");
    a_body_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_END) |->
            (r_len >= MIN_FRAME && r_len <= MAX_LEN && idx_w < r_len))
        else $error("frame body with bad length or index");
`endif

endmodule

FILE: rtl/core/alfr_obuf.sv
// Two-entry result queue that decouples the parser from the output stall.
// Depends on alfr_pkg for the result type.
module alfr_obuf
    import alfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_result    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop      = o_valid && !i_stall;
    assign o_valid  = r_count != 2'd0;
    assign o_full   = r_count == 2'd2;
    assign o_result = r_mem[r_rptr];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_result;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue overflow");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full result queue");
    a_ptr_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wptr == r_rptr)
        else $error("queue pointers disagree with occupancy");
`endif

endmodule

FILE: rtl/core/ascii_length_frame_receiver.sv
// ASCII length frame receiver: takes one byte per item and returns, for every byte, the
// byte, its index in the current frame and a status (in frame, complete, header, length
// or trailer error). A frame is "ECU", two unchecked version bytes, a four-digit decimal
// total length L (12 to MAX_FRAME), payload, and "END" in the last three bytes; any
// mismatch drops the frame and the next byte starts a new one. Throughput is one byte
// per cycle while the result queue has room: the parser state updates when a byte is
// accepted and its result is registered into a two-entry output queue, so input is
// stalled only while that queue holds two unread results. No clearing pass after reset.
// Depends on alfr_pkg, alfr_ctrl and alfr_obuf.
module ascii_length_frame_receiver
    import alfr_pkg::*;
#(
    parameter int MAX_FRAME = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte_echo,
    output logic [9:0]  o_byte_index,
    output logic [2:0]  o_status,
    output logic [10:0] o_frame_length
);

    logic    accept;
    logic    full;
    t_result step_result;
    t_result out_result;

    // Take a byte whenever the result queue has room
    assign o_stall = full;
    assign accept  = i_valid && !full;

    alfr_ctrl #(
        .MAX_FRAME(MAX_FRAME)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_rx_byte),
        .o_result(step_result)
    );

    alfr_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_result(step_result),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(out_result)
    );

    // Drive the result fields
    assign o_byte_echo    = out_result.byte_echo;
    assign o_byte_index   = out_result.byte_index;
    assign o_status       = out_result.status;
    assign o_frame_length = out_result.frame_length;

endmodule
